// ----- rtl/bale_pkg.sv -----
// Shared types and constants for the bounded array list engine.
// Depends on nothing; every other file of the block imports it.
package bale_pkg;

  // Fixed field widths
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int POS_W    = 8;
  localparam int SIZE_W   = 8;
  localparam int STATUS_W = 2;

  // Default list depth and the width of the cell-side index compares
  localparam int DEF_CAPACITY = 128;
  localparam int DEF_CMP_W    = 9;

  // Cells OR-ed together in the first level of the select tree
  localparam int GRP_SIZE = 32;

  // Operation codes on in_mode
  localparam logic [MODE_W-1:0] M_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] M_POP    = 3'd1;
  localparam logic [MODE_W-1:0] M_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] M_ERASE  = 3'd3;
  localparam logic [MODE_W-1:0] M_RESIZE = 3'd4;
  localparam logic [MODE_W-1:0] M_ASSIGN = 3'd5;
  localparam logic [MODE_W-1:0] M_READ   = 3'd6;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

  // Update applied to every cell in the accept cycle
  typedef enum logic [2:0] {
    C_HOLD,
    C_PUSH,
    C_INSERT,
    C_ERASE,
    C_RESIZE,
    C_ASSIGN
  } cell_op_t;

  typedef struct packed {
    cell_op_t                  op;
    logic signed [DATA_W-1:0]  value;
  } cell_ctrl_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_GATHER = 3'b010,
    S_REDUCE = 3'b100
  } state_t;

endpackage

// ----- rtl/bale_cell.sv -----
// One list slot: holds one element, shifts with its neighbors on insert/erase
// and drives masked taps for the read and last-element select tree.
// Depends on bale_pkg.
module bale_cell #(
  parameter int IDX   = 0,
  parameter int CMP_W = bale_pkg::DEF_CMP_W
) (
  input  logic                                 clk,
  input  bale_pkg::cell_ctrl_t                 ctrl,
  input  logic [CMP_W-1:0]                     cur_count,
  input  logic [CMP_W-1:0]                     pos,
  input  logic [CMP_W-1:0]                     new_count,
  input  logic signed [bale_pkg::DATA_W-1:0]   left_data,
  input  logic signed [bale_pkg::DATA_W-1:0]   right_data,
  input  logic [CMP_W-1:0]                     rd_sel,
  input  logic                                 rd_en,
  input  logic [CMP_W-1:0]                     last_sel,
  input  logic                                 last_en,
  output logic signed [bale_pkg::DATA_W-1:0]   data_out,
  output logic signed [bale_pkg::DATA_W-1:0]   rd_tap,
  output logic signed [bale_pkg::DATA_W-1:0]   last_tap
);
  import bale_pkg::*;

  localparam logic [CMP_W-1:0] IDX_V  = CMP_W'(IDX);
  localparam logic [CMP_W-1:0] IDX_P1 = CMP_W'(IDX + 1);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // Next value of this slot from its own index compares
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      C_PUSH: begin
        if (IDX_V == cur_count) data_nxt = ctrl.value;
      end
      C_INSERT: begin
        if (IDX_V == pos) data_nxt = ctrl.value;
        else if (IDX_V > pos && IDX_V <= cur_count) data_nxt = left_data;
      end
      C_ERASE: begin
        if (IDX_V >= pos && IDX_P1 < cur_count) data_nxt = right_data;
      end
      C_RESIZE: begin
        if (IDX_V >= cur_count && IDX_V < new_count) data_nxt = '0;
      end
      C_ASSIGN: begin
        if (IDX_V < new_count) data_nxt = ctrl.value;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Taps for the select tree; zero unless this slot is the one picked
  assign data_out = data_r;
  assign rd_tap   = (rd_en && IDX_V == rd_sel) ? data_r : '0;
  assign last_tap = (last_en && IDX_V == last_sel) ? data_r : '0;

endmodule

// ----- rtl/bounded_array_list_engine.sv -----
// Top level of the bounded array list engine: operation decode, the row of
// slot cells, a two-level registered select tree and the result register.
// Depends on bale_pkg and bale_cell.
//
//  channel  | ports                                       | transfer
//  ---------+---------------------------------------------+---------------------------
//  input    | in_mode, in_position, in_count, in_value     | start high, busy low
//  result   | out_status, out_size, out_is_empty,          | out_valid high, one cycle
//           | out_first_value, out_last_value, out_read_value
//
// For every operation the cell row applies the update at the accept edge,
// then the read and last-element selects pass through a registered group OR
// stage and a final OR stage before out_valid.
// A new item may be started in the cycle that out_valid is high.
// rst_n (synchronous) empties the list; element contents are not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bounded_array_list_engine #(
  parameter int CAPACITY = bale_pkg::DEF_CAPACITY
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [bale_pkg::MODE_W-1:0]           in_mode,
  input  logic [bale_pkg::POS_W-1:0]            in_position,
  input  logic [bale_pkg::POS_W-1:0]            in_count,
  input  logic signed [bale_pkg::DATA_W-1:0]    in_value,
  output logic                                  out_valid,
  output logic [bale_pkg::STATUS_W-1:0]         out_status,
  output logic [bale_pkg::SIZE_W-1:0]           out_size,
  output logic                                  out_is_empty,
  output logic signed [bale_pkg::DATA_W-1:0]    out_first_value,
  output logic signed [bale_pkg::DATA_W-1:0]    out_last_value,
  output logic signed [bale_pkg::DATA_W-1:0]    out_read_value
);
  import bale_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int NGRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;

  localparam logic [CMP_W-1:0] CAP_X = CMP_W'(CAPACITY);

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      acc;

  // Decode results
  cell_op_t                  op_dec;
  logic [STATUS_W-1:0]       status_dec;
  logic                      rd_en_dec;
  cell_ctrl_t                ctrl;

  logic [CMP_W-1:0]          cur_x, pos_x, cnt_x, nxt_x;

  // Held between accept and result
  logic [STATUS_W-1:0]       status_r;
  logic [CMP_W-1:0]          rd_sel_r, last_sel_r;
  logic                      rd_en_r, last_en_r;

  // Cell row
  logic signed [DATA_W-1:0]  cell_data [CAPACITY];
  logic signed [DATA_W-1:0]  rd_tap    [CAPACITY];
  logic signed [DATA_W-1:0]  last_tap  [CAPACITY];

  // Select tree
  logic signed [DATA_W-1:0]  grp_rd_nxt   [NGRP];
  logic signed [DATA_W-1:0]  grp_last_nxt [NGRP];
  logic signed [DATA_W-1:0]  grp_rd_r     [NGRP];
  logic signed [DATA_W-1:0]  grp_last_r   [NGRP];
  logic signed [DATA_W-1:0]  first_r;
  logic signed [DATA_W-1:0]  rd_all, last_all;

  // Result register
  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic [SIZE_W-1:0]         out_size_r;
  logic                      out_is_empty_r;
  logic signed [DATA_W-1:0]  out_first_r, out_last_r, out_read_r;

  assign busy = (state_r != S_IDLE);
  assign acc  = start && !busy;

  assign cur_x = CMP_W'(count_r);
  assign pos_x = CMP_W'(in_position);
  assign cnt_x = CMP_W'(in_count);
  assign nxt_x = CMP_W'(count_nxt);

  // Operation decode against the current size
  always_comb begin
    op_dec     = C_HOLD;
    status_dec = ST_DONE;
    rd_en_dec  = 1'b0;
    count_nxt  = count_r;
    case (in_mode)
      M_PUSH: begin
        if (cur_x >= CAP_X) begin
          status_dec = ST_REFUSED;
        end else begin
          op_dec    = C_PUSH;
          count_nxt = count_r + 1'b1;
        end
      end
      M_POP: begin
        if (count_r == '0) status_dec = ST_IGNORED;
        else               count_nxt  = count_r - 1'b1;
      end
      M_INSERT: begin
        if (pos_x > cur_x) begin
          status_dec = ST_IGNORED;
        end else if (cur_x >= CAP_X) begin
          status_dec = ST_REFUSED;
        end else begin
          op_dec    = C_INSERT;
          count_nxt = count_r + 1'b1;
        end
      end
      M_ERASE: begin
        if (pos_x >= cur_x) begin
          status_dec = ST_IGNORED;
        end else begin
          op_dec    = C_ERASE;
          count_nxt = count_r - 1'b1;
        end
      end
      M_RESIZE: begin
        if (cnt_x > CAP_X) begin
          status_dec = ST_REFUSED;
        end else begin
          op_dec    = C_RESIZE;
          count_nxt = CNT_W'(cnt_x);
        end
      end
      M_ASSIGN: begin
        if (cnt_x > CAP_X) begin
          status_dec = ST_REFUSED;
        end else begin
          op_dec    = C_ASSIGN;
          count_nxt = CNT_W'(cnt_x);
        end
      end
      M_READ: begin
        if (pos_x >= cur_x) status_dec = ST_IGNORED;
        else                rd_en_dec  = 1'b1;
      end
      default: status_dec = ST_IGNORED;
    endcase
  end

  // Cells only see an update in the accept cycle
  assign ctrl.op    = acc ? op_dec : C_HOLD;
  assign ctrl.value = in_value;

  // Row of slot cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d, right_d;
    if (i == 0) begin : g_lo
      assign left_d = '0;
    end else begin : g_lo
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign right_d = '0;
    end else begin : g_hi
      assign right_d = cell_data[i+1];
    end
    bale_cell #(
      .IDX   (i),
      .CMP_W (CMP_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .cur_count  (cur_x),
      .pos        (pos_x),
      .new_count  (cnt_x),
      .left_data  (left_d),
      .right_data (right_d),
      .rd_sel     (rd_sel_r),
      .rd_en      (rd_en_r),
      .last_sel   (last_sel_r),
      .last_en    (last_en_r),
      .data_out   (cell_data[i]),
      .rd_tap     (rd_tap[i]),
      .last_tap   (last_tap[i])
    );
  end

  // Sequencer: accept, group OR, final OR
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (acc) state_nxt = S_GATHER;
      S_GATHER: state_nxt = S_REDUCE;
      S_REDUCE: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_REDUCE);
      if (acc) count_r <= count_nxt;
    end
  end

  // Per-item selects, captured at accept
  always_ff @(posedge clk) begin
    if (acc) begin
      status_r   <= status_dec;
      rd_sel_r   <= pos_x;
      rd_en_r    <= rd_en_dec;
      last_sel_r <= nxt_x - 1'b1;
      last_en_r  <= (count_nxt != '0);
    end
  end

  // First level: OR the taps of each group of cells
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_rd_nxt[g]   = '0;
      grp_last_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g * GRP_SIZE + k < CAPACITY) begin
          grp_rd_nxt[g]   = grp_rd_nxt[g]   | rd_tap[g * GRP_SIZE + k];
          grp_last_nxt[g] = grp_last_nxt[g] | last_tap[g * GRP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GATHER) begin
      grp_rd_r   <= grp_rd_nxt;
      grp_last_r <= grp_last_nxt;
      first_r    <= last_en_r ? cell_data[0] : '0;
    end
  end

  // Second level: OR across the groups
  always_comb begin
    rd_all   = '0;
    last_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all   = rd_all   | grp_rd_r[g];
      last_all = last_all | grp_last_r[g];
    end
  end

  // Result register, shown for one cycle after the final OR
  always_ff @(posedge clk) begin
    if (state_r == S_REDUCE) begin
      out_status_r   <= status_r;
      out_size_r     <= SIZE_W'(count_r);
      out_is_empty_r <= (count_r == '0);
      out_first_r    <= first_r;
      out_last_r     <= last_all;
      out_read_r     <= rd_all;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_size        = out_size_r;
  assign out_is_empty    = out_is_empty_r;
  assign out_first_value = out_first_r;
  assign out_last_value  = out_last_r;
  assign out_read_value  = out_read_r;

  // Checks
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("result strobe not three cycles after transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("block not busy after transfer");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CMP_W'(count_r) <= CAP_X))
    else $error("element count above capacity");

  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |->
      (out_first_value == '0 && out_last_value == '0 && out_read_value == '0))
    else $error("empty list reports nonzero element");

endmodule

// ----- tb/bale_checker.sv -----
// Checker for the bounded array list engine: watches the operation and result
// channels, keeps its own copy of the list and compares every result transfer.
// Depends on bale_pkg.
module bale_checker #(
  parameter int CAPACITY = bale_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [bale_pkg::MODE_W-1:0]         in_mode,
  input  logic [bale_pkg::POS_W-1:0]          in_position,
  input  logic [bale_pkg::POS_W-1:0]          in_count,
  input  logic signed [bale_pkg::DATA_W-1:0]  in_value,
  input  logic                                out_valid,
  input  logic [bale_pkg::STATUS_W-1:0]       out_status,
  input  logic [bale_pkg::SIZE_W-1:0]         out_size,
  input  logic                                out_is_empty,
  input  logic signed [bale_pkg::DATA_W-1:0]  out_first_value,
  input  logic signed [bale_pkg::DATA_W-1:0]  out_last_value,
  input  logic signed [bale_pkg::DATA_W-1:0]  out_read_value,
  output int                                  err_count,
  output int                                  pending,
  output int                                  checked
);
  import bale_pkg::*;

  // What one operation reports about the list
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic [SIZE_W-1:0]        len;
    logic                     is_empty;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;
    logic signed [DATA_W-1:0] read_value;
  } list_view_t;

  logic signed [DATA_W-1:0] slots [CAPACITY];
  int                       slot_count;
  list_view_t               views_q[$];
  int                       mismatches;
  int                       compared;

  initial begin
    err_count = 0;
    pending   = 0;
    checked   = 0;
  end

  // Apply one operation to the shadow list and return what it should report
  function automatic list_view_t list_apply(input logic [MODE_W-1:0] mode,
                                            input logic [POS_W-1:0] pos_in,
                                            input logic [POS_W-1:0] cnt_in,
                                            input logic signed [DATA_W-1:0] val);
    list_view_t v;
    int         pos;
    int         cnt;
    int         i;
    v      = '0;
    pos    = pos_in;
    cnt    = cnt_in;
    v.status = ST_DONE;
    case (mode)
      M_PUSH: begin
        if (slot_count >= CAPACITY) begin
          v.status = ST_REFUSED;
        end else begin
          slots[slot_count] = val;
          slot_count++;
        end
      end
      M_POP: begin
        if (slot_count == 0) v.status = ST_IGNORED;
        else slot_count--;
      end
      // Range is checked before fullness
      M_INSERT: begin
        if (pos > slot_count) begin
          v.status = ST_IGNORED;
        end else if (slot_count >= CAPACITY) begin
          v.status = ST_REFUSED;
        end else begin
          for (i = slot_count; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = val;
          slot_count++;
        end
      end
      M_ERASE: begin
        if (pos >= slot_count) begin
          v.status = ST_IGNORED;
        end else begin
          for (i = pos; i + 1 < slot_count; i++) slots[i] = slots[i+1];
          slot_count--;
        end
      end
      // Growing zeroes every newly exposed slot
      M_RESIZE: begin
        if (cnt > CAPACITY) begin
          v.status = ST_REFUSED;
        end else begin
          for (i = slot_count; i < cnt; i++) slots[i] = '0;
          slot_count = cnt;
        end
      end
      M_ASSIGN: begin
        if (cnt > CAPACITY) begin
          v.status = ST_REFUSED;
        end else begin
          for (i = 0; i < cnt; i++) slots[i] = val;
          slot_count = cnt;
        end
      end
      M_READ: begin
        if (pos >= slot_count) v.status = ST_IGNORED;
        else v.read_value = slots[pos];
      end
      default: v.status = ST_IGNORED;
    endcase
    v.len      = slot_count[SIZE_W-1:0];
    v.is_empty = (slot_count == 0);
    if (slot_count > 0) begin
      v.first_value = slots[0];
      v.last_value  = slots[slot_count-1];
    end
    return v;
  endfunction

  // Compare result transfers first, then record the operation accepted at this edge
  always @(posedge clk) begin
    list_view_t exp_v;
    list_view_t act_v;
    if (!rst_n) begin
      slot_count = 0;
      for (int i = 0; i < CAPACITY; i++) slots[i] = '0;
      views_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        act_v = '{out_status, out_size, out_is_empty,
                  out_first_value, out_last_value, out_read_value};
        if (views_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result transfer with no operation outstanding (st=%0d sz=%0d)",
                     out_status, out_size);
        end else begin
          exp_v = views_q.pop_front();
          compared++;
          if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: exp st=%0d sz=%0d em=%0b first=%0d last=%0d rd=%0d",
                       exp_v.status, exp_v.len, exp_v.is_empty, exp_v.first_value,
                       exp_v.last_value, exp_v.read_value);
              $display("       got st=%0d sz=%0d em=%0b first=%0d last=%0d rd=%0d",
                       act_v.status, act_v.len, act_v.is_empty, act_v.first_value,
                       act_v.last_value, act_v.read_value);
            end
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0)
        views_q.insert(views_q.size(),
                       list_apply(in_mode, in_position, in_count, in_value));
    end
    err_count <= mismatches;
    pending   <= views_q.size();
    checked   <= compared;
  end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the bounded array list engine: clock, reset, operation
// stimulus and the verdict. Depends on bale_pkg, bale_checker and the block.
module tb_top;
  import bale_pkg::*;

  localparam int                CAP          = DEF_CAPACITY;
  localparam int                RANDOM_OPS   = 1550;
  localparam int                LIMIT_CYCLES = 200000;
  localparam logic [MODE_W-1:0] M_UNUSED     = 3'd7;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     start       = 1'b0;
  logic [MODE_W-1:0]        in_mode     = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic [POS_W-1:0]         in_count    = '0;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic                     busy;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [SIZE_W-1:0]        out_size;
  logic                     out_is_empty;
  logic signed [DATA_W-1:0] out_first_value;
  logic signed [DATA_W-1:0] out_last_value;
  logic signed [DATA_W-1:0] out_read_value;
  int                       err_count;
  int                       pending;
  int                       checked;

  // Stimulus bookkeeping: list length as the stimulus sees it, not a check
  int cycles    = 0;
  int est_size  = 0;
  int peak_size = 0;
  int sent      = 0;
  int full_hits = 0;
  bit idle_on   = 1'b1;

  always #6 clk = ~clk;

  bounded_array_list_engine #(.CAPACITY(CAP)) dut (.*);

  bale_checker #(.CAPACITY(CAP)) u_checker (.*);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Send one operation and wait for its transfer; start stays high across back-to-back ops
  task automatic issue(input logic [MODE_W-1:0] m, input int p, input int c,
                       input logic signed [DATA_W-1:0] v);
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_mode     <= m;
    in_position <= p[POS_W-1:0];
    in_count    <= c[POS_W-1:0];
    in_value    <= v;
    do @(posedge clk); while (busy !== 1'b0);
    sent++;
    if (est_size == CAP && (m == M_PUSH || m == M_INSERT)) full_hits++;
    case (m)
      M_PUSH:   if (est_size < CAP) est_size++;
      M_POP:    if (est_size > 0) est_size--;
      M_INSERT: if (p <= est_size && est_size < CAP) est_size++;
      M_ERASE:  if (p < est_size) est_size--;
      M_RESIZE, M_ASSIGN: if (c <= CAP) est_size = c;
      default: ;
    endcase
    if (est_size > peak_size) peak_size = est_size;
  endtask

  initial begin
    // Cumulative mode weights per phase: grow, shrink, mixed
    int                thr [3][8];
    logic [MODE_W-1:0] mode_order [8];
    int                phase;
    int                roll;
    int                k;
    int                pos;
    int                cnt;
    logic signed [DATA_W-1:0] val;

    thr = '{'{40, 60, 68, 76, 90, 94, 98, 100},
            '{10, 18, 45, 70, 88, 93, 97, 100},
            '{18, 32, 46, 60, 80, 88, 96, 100}};
    mode_order = '{M_PUSH, M_INSERT, M_POP, M_ERASE, M_READ, M_RESIZE, M_ASSIGN, M_UNUSED};
    phase = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list corners
    issue(M_POP,    0, 0, 0);
    issue(M_ERASE,  0, 0, 0);
    issue(M_READ,   0, 0, 0);
    issue(M_INSERT, 1, 0, 32'sd11);
    // Extremes of the value, front, append and middle inserts
    issue(M_PUSH,   0, 0, 32'sh8000_0000);
    issue(M_PUSH,   0, 0, 32'sh7fff_ffff);
    issue(M_INSERT, 0, 0, 32'sd5);
    issue(M_INSERT, 3, 0, 32'sd9);
    issue(M_INSERT, 2, 0, -32'sd7);
    issue(M_READ,   2, 0, 0);
    issue(M_ERASE,  1, 0, 0);
    issue(M_ERASE,  3, 0, 0);
    // Resize same, shrink, then grow over dropped entries
    issue(M_RESIZE, 0, 3, 0);
    issue(M_RESIZE, 0, 1, 0);
    issue(M_RESIZE, 0, 6, 0);
    issue(M_READ,   4, 0, 0);
    // Full list
    issue(M_ASSIGN, 0, CAP, -32'sd3);
    issue(M_PUSH,   0, 0, 32'sd1);
    issue(M_INSERT, 5, 0, 32'sd1);
    issue(M_INSERT, 200, 0, 32'sd1);
    issue(M_RESIZE, 0, CAP + 1, 0);
    issue(M_ASSIGN, 0, 255, 32'sd2);
    issue(M_ERASE,  0, 0, 0);
    issue(M_INSERT, CAP - 2, 0, 32'sd77);
    issue(M_READ,   CAP - 1, 0, 0);
    issue(M_READ,   CAP, 0, 0);
    issue(M_UNUSED, 255, 255, -32'sd1);
    issue(M_RESIZE, 0, 0, 0);

    // Random: phases bias the list toward growth, shrinkage or churn
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n % 100 == 0) phase = $urandom_range(0, 2);
      roll = $urandom_range(0, 99);
      k = 0;
      while (roll >= thr[phase][k]) k++;

      roll = $urandom_range(0, 19);
      if (roll < 14) pos = $urandom_range(0, est_size);
      else if (roll < 17) pos = est_size + $urandom_range(0, 3);
      else pos = $urandom_range(0, 255);
      if (pos > 255) pos = 255;

      roll = $urandom_range(0, 19);
      if (roll < 13) cnt = $urandom_range(0, CAP);
      else if (roll < 15) cnt = est_size;
      else if (roll < 17) cnt = ($urandom_range(0, 1) != 0) ? CAP : 0;
      else cnt = $urandom_range(CAP + 1, 255);

      roll = $urandom_range(0, 19);
      if (roll == 0) val = 32'sh8000_0000;
      else if (roll == 1) val = 32'sh7fff_ffff;
      else val = $urandom;

      issue(mode_order[k], pos, cnt, val);
    end
    start <= 1'b0;

    // Drain, then allow a few cycles for anything unexpected
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d list operations (%0d push/insert on a full list), peak length %0d.",
             sent, full_hits, peak_size);
    $display("Compared %0d result transfers, %0d mismatches.", checked, err_count);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
